>>> src/svmsgd_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and types for the linear SVM SGD update core.
// No dependencies; every other file of the block imports this package.
package svmsgd_pkg;

   localparam int FEAT_W   = 16;  // signed Q2.14 feature
   localparam int WGT_W    = 32;  // signed Q8.24 weight
   localparam int STEP_W   = 16;  // unsigned Q0.16 learning rate
   localparam int LAMBDA_W = 32;  // unsigned Q0.32 regularization
   localparam int FACTOR_W = 32;  // unsigned Q0.32 decay factor
   localparam int PROD_W   = FEAT_W + WGT_W;  // Q10.38 feature times weight
   localparam int DATA_W   = 28;  // rounded data term, Q.24
   localparam int MARGIN_W = 40;  // signed Q16.24 margin
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_LAMBDA = 1'd1;

   localparam logic [STEP_W-1:0]   STEP_RESET   = 16'd64225;
   localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 32'd4295;

   localparam logic signed [MARGIN_W-1:0] MARGIN_MAX = {1'b0, {(MARGIN_W-1){1'b1}}};
   localparam logic signed [MARGIN_W-1:0] MARGIN_MIN = {1'b1, {(MARGIN_W-1){1'b0}}};
   localparam logic signed [MARGIN_W-1:0] ONE_Q24    = 40'sd16777216;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_UPD  = 4'b1000
   } state_type;

   typedef struct packed {
      logic mul_en;    // form feature products and data term
      logic dec_en;    // form decay product
      logic upd_en;    // write the new weight
      logic hinge;     // apply the data term
      logic positive;  // label is +1
   } lane_ctrl_type;

endpackage

>>> src/linear_svm_sgd_update_core.sv
`timescale 1ns / 1ps
// Top level of the linear SVM SGD update core: handshake, control registers,
// sequencer and output register. Uses svmsgd_pkg, svmsgd_lane, svmsgd_merge.
//
//   channel  dir  handshake           payload
//   req      in   req_tvalid/tready   tdata: feat_0..feat_N-1, tuser: label_positive
//   rsp      out  rsp_tvalid/tready   tdata: margin, tuser: hinge_active
//   csr      in   csr_wen             csr_index, csr_wdata
//
// A request goes through capture, lane multiplies, merge plus decay multiply and
// weight write; the weight feedback through the lanes allows no overlap of requests.
// Reset is synchronous; weights clear to zero, step_size and reg_lambda load
// their defaults. A held result stalls only the weight-write step.
module linear_svm_sgd_update_core #(
   parameter int FEATURES = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [FEATURES*svmsgd_pkg::FEAT_W-1:0]     req_tdata,  // feat_0 .. feat_N-1
   input  logic                                       req_tuser,  // label_positive
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [svmsgd_pkg::MARGIN_W-1:0]            rsp_tdata,  // margin
   output logic                                       rsp_tuser,  // hinge_active
   input  logic                                       csr_wen,
   input  logic [svmsgd_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [svmsgd_pkg::CSR_W-1:0]               csr_wdata
);
   import svmsgd_pkg::*;

   state_type state_ff, state_in;

   logic [STEP_W-1:0]   step_ff;
   logic [LAMBDA_W-1:0] lambda_ff;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [STEP_W+LAMBDA_W-1:0] factor_prod;

   logic signed [FEAT_W-1:0] feat_ff [FEATURES];
   logic                     positive_ff;

   logic                       rsp_valid_ff;
   logic [MARGIN_W-1:0]        rsp_data_ff;
   logic                       rsp_user_ff;

   logic signed [PROD_W-1:0]   prod [FEATURES];
   logic signed [MARGIN_W-1:0] margin;
   logic                       hinge;
   logic                       out_free;
   logic                       accept;
   lane_ctrl_type              lane_ctrl;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_UPD;
         ST_UPD:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      lane_ctrl.mul_en   = (state_ff == ST_MUL);
      lane_ctrl.dec_en   = (state_ff == ST_SUM);
      lane_ctrl.upd_en   = (state_ff == ST_UPD) && out_free;
      lane_ctrl.hinge    = hinge;
      lane_ctrl.positive = positive_ff;
   end

   // decay factor follows the registers; rounded Q0.48 to Q0.32
   always_comb begin
      factor_prod = step_ff * lambda_ff;
      factor_in   = FACTOR_W'(({1'b0, factor_prod} + (STEP_W+LAMBDA_W+1)'(32768)) >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_RESET;
         lambda_ff    <= LAMBDA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_STEP_SIZE:  step_ff   <= csr_wdata[STEP_W-1:0];
               CSR_REG_LAMBDA: lambda_ff <= csr_wdata[LAMBDA_W-1:0];
               default: ;
            endcase
         end
         if (lane_ctrl.upd_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      factor_ff <= factor_in;
      if (accept) begin
         positive_ff <= req_tuser;
         for (int i = 0; i < FEATURES; i++) begin
            feat_ff[i] <= req_tdata[i*FEAT_W +: FEAT_W];
         end
      end
      if (lane_ctrl.upd_en) begin
         rsp_data_ff <= margin;
         rsp_user_ff <= hinge;
      end
   end

   for (genvar g = 0; g < FEATURES; g++) begin : g_lane
      svmsgd_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .feat   (feat_ff[g]),
         .step   (step_ff),
         .factor (factor_ff),
         .prod   (prod[g])
      );
   end

   svmsgd_merge #(
      .FEATURES (FEATURES)
   ) u_merge (
      .clock    (clock),
      .en       (state_ff == ST_SUM),
      .positive (positive_ff),
      .prod     (prod),
      .margin   (margin),
      .hinge    (hinge)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> src/svmsgd_lane.sv
`timescale 1ns / 1ps
// One weight lane: holds a Q8.24 weight, forms its product with the feature,
// the decay and data terms, and the saturated update. Depends on svmsgd_pkg.
module svmsgd_lane (
   input  logic                                      clock,
   input  logic                                      reset,
   input  svmsgd_pkg::lane_ctrl_type                 ctrl,
   input  logic signed [svmsgd_pkg::FEAT_W-1:0]      feat,
   input  logic [svmsgd_pkg::STEP_W-1:0]             step,
   input  logic [svmsgd_pkg::FACTOR_W-1:0]           factor,
   output logic signed [svmsgd_pkg::PROD_W-1:0]      prod
);
   import svmsgd_pkg::*;

   localparam int SF_W = STEP_W + FEAT_W + 1;
   localparam int DP_W = WGT_W + FACTOR_W + 1;
   localparam int DEC_W = WGT_W + 1;
   localparam int NW_W = WGT_W + 4;

   logic signed [WGT_W-1:0]  weight_ff, weight_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic signed [DP_W-1:0]   dprod_ff, dprod_in;

   logic signed [SF_W-1:0]   step_feat;
   logic signed [DP_W-1:0]   dprod_rnd;
   logic signed [DEC_W-1:0]  decay;
   logic signed [DATA_W-1:0] data_signed;
   logic signed [NW_W-1:0]   new_weight;

   always_comb begin
      prod_in   = feat * weight_ff;
      step_feat = $signed({1'b0, step}) * feat;
      data_in   = DATA_W'((step_feat + SF_W'(32)) >>> 6);
      dprod_in  = weight_ff * $signed({1'b0, factor});

      // round decay product to Q.24, half toward plus infinity
      dprod_rnd   = dprod_ff + $signed({{(DP_W-32){1'b0}}, 32'h8000_0000});
      decay       = DEC_W'(dprod_rnd >>> 32);
      data_signed = ctrl.positive ? data_ff : -data_ff;
      new_weight  = NW_W'(weight_ff) - NW_W'(decay);
      if (ctrl.hinge) begin
         new_weight = new_weight + NW_W'(data_signed);
      end
      if (new_weight > $signed({{(NW_W-WGT_W+1){1'b0}}, {(WGT_W-1){1'b1}}})) begin
         weight_in = {1'b0, {(WGT_W-1){1'b1}}};
      end else if (new_weight < $signed({{(NW_W-WGT_W+1){1'b1}}, {(WGT_W-1){1'b0}}})) begin
         weight_in = {1'b1, {(WGT_W-1){1'b0}}};
      end else begin
         weight_in = WGT_W'(new_weight);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
      end else if (ctrl.upd_en) begin
         weight_ff <= weight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
         data_ff <= data_in;
      end
      if (ctrl.dec_en) begin
         dprod_ff <= dprod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> src/svmsgd_merge.sv
`timescale 1ns / 1ps
// Merge stage: sums the lane products, applies the label, rounds to Q.24,
// saturates the margin and decides the hinge. Depends on svmsgd_pkg.
module svmsgd_merge #(
   parameter int FEATURES = 8
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic                                   positive,
   input  logic signed [svmsgd_pkg::PROD_W-1:0]   prod [FEATURES],
   output logic signed [svmsgd_pkg::MARGIN_W-1:0] margin,
   output logic                                   hinge
);
   import svmsgd_pkg::*;

   localparam int SUM_W = PROD_W + $clog2(FEATURES + 1) + 1;
   localparam int EXT_W = (SUM_W > MARGIN_W) ? SUM_W + 1 : MARGIN_W + 1;

   logic signed [SUM_W-1:0]    dot;
   logic signed [SUM_W-1:0]    rnd;
   logic signed [EXT_W-1:0]    rnd_ext;
   logic signed [MARGIN_W-1:0] margin_in;
   logic signed [MARGIN_W-1:0] margin_ff;
   logic                       hinge_ff;

   always_comb begin
      dot = '0;
      for (int i = 0; i < FEATURES; i++) begin
         dot = dot + SUM_W'(prod[i]);
      end
      if (!positive) begin
         dot = -dot;
      end
      rnd     = (dot + SUM_W'(8192)) >>> 14;
      rnd_ext = EXT_W'(rnd);
      if (rnd_ext > EXT_W'(MARGIN_MAX)) begin
         margin_in = MARGIN_MAX;
      end else if (rnd_ext < EXT_W'(MARGIN_MIN)) begin
         margin_in = MARGIN_MIN;
      end else begin
         margin_in = MARGIN_W'(rnd_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         margin_ff <= margin_in;
         hinge_ff  <= (margin_in <= ONE_Q24);
      end
   end

   assign margin = margin_ff;
   assign hinge  = hinge_ff;

endmodule

>>> test/svm_sgd_checker.sv
`timescale 1ns / 1ps
// Checker for the linear SVM SGD update core: watches the request, response and
// register ports, trains its own weight vector and compares every response.
// Depends on svmsgd_pkg only.
module svm_sgd_checker #(
   parameter int FEATURES = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   input  logic [FEATURES*svmsgd_pkg::FEAT_W-1:0]  req_tdata,  // feat_0 .. feat_N-1
   input  logic                                    req_tuser,  // label_positive
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic [svmsgd_pkg::MARGIN_W-1:0]         rsp_tdata,  // margin
   input  logic                                    rsp_tuser,  // hinge_active
   input  logic                                    csr_wen,
   input  logic [svmsgd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [svmsgd_pkg::CSR_W-1:0]            csr_wdata,
   output int                                      mismatch_count,
   output int                                      margins_due
);
   import svmsgd_pkg::*;

   typedef struct packed {
      logic [MARGIN_W-1:0] margin;
      logic                hinge;
   } margin_rec_type;

   logic [STEP_W-1:0]          step_q16;
   logic [LAMBDA_W-1:0]        lambda_q32;
   logic signed [WGT_W-1:0]    wgt [FEATURES];
   margin_rec_type             predicted_margins [$];
   margin_rec_type             oldest;

   // floor((v + 2^(s-1)) / 2^s): round half toward plus infinity
   function automatic longint rnd_shift(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // One SGD step on the hinge loss: returns margin and hinge flag, updates weights.
   function automatic margin_rec_type sgd_step(input logic [FEATURES*FEAT_W-1:0] feats,
                                               input logic positive);
      margin_rec_type           res;
      logic signed [FEAT_W-1:0] f;
      longint                   dot;
      longint                   mrg;
      longint                   factor;
      longint                   decay;
      longint                   data;
      longint                   nw;
      logic                     hinge;
      dot = 0;
      for (int i = 0; i < FEATURES; i++) begin
         f = feats[i*FEAT_W +: FEAT_W];
         dot += longint'(f) * longint'(wgt[i]);
      end
      if (!positive) dot = -dot;
      mrg = clamp(rnd_shift(dot, 14), MARGIN_W);
      hinge = (mrg <= (longint'(1) <<< 24));
      factor = rnd_shift(longint'(step_q16) * longint'(lambda_q32), 16);
      for (int i = 0; i < FEATURES; i++) begin
         f = feats[i*FEAT_W +: FEAT_W];
         // the decay term and the update both use the old weight
         decay = rnd_shift(longint'(wgt[i]) * factor, 32);
         nw = longint'(wgt[i]) - decay;
         if (hinge) begin
            data = rnd_shift(longint'(step_q16) * longint'(f), 6);
            nw = positive ? nw + data : nw - data;
         end
         wgt[i] = WGT_W'(clamp(nw, WGT_W));
      end
      res.margin = MARGIN_W'(mrg);
      res.hinge = hinge;
      return res;
   endfunction

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         step_q16 = STEP_RESET;
         lambda_q32 = LAMBDA_RESET;
         foreach (wgt[i]) wgt[i] = '0;
         predicted_margins.delete();
         margins_due = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_STEP_SIZE:  step_q16 = csr_wdata[STEP_W-1:0];
               CSR_REG_LAMBDA: lambda_q32 = csr_wdata[LAMBDA_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predicted_margins.push_back(sgd_step(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_margins.size() == 0) begin
               log_mismatch($sformatf("response with no request pending: margin %0d hinge %0b",
                                      $signed(rsp_tdata), rsp_tuser));
            end else begin
               oldest = predicted_margins.pop_front();
               if (rsp_tdata !== oldest.margin || rsp_tuser !== oldest.hinge)
                  log_mismatch($sformatf("expected margin %0d hinge %0b, got margin %0d hinge %0b",
                                         $signed(oldest.margin), oldest.hinge,
                                         $signed(rsp_tdata), rsp_tuser));
            end
         end
         margins_due = predicted_margins.size();
      end
   end

endmodule

>>> test/linear_svm_sgd_update_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for linear_svm_sgd_update_core: drives requests, register writes
// and response back-pressure; svm_sgd_checker predicts and compares.
// Depends on svmsgd_pkg, the core and svm_sgd_checker.
module linear_svm_sgd_update_core_tb;
   import svmsgd_pkg::*;

   localparam int NFEAT           = 8;
   localparam int PHASE_ITEMS     = 230;
   localparam int HOLD_OFF_CYCLES = 300;

   // directed rows: value for features 1..7, row 0 in the low bits
   localparam logic [159:0] DIR_VALS = {16'h7FFF, 16'hFFFF, 16'h0001, 16'h0000, 16'hAAAA,
                                        16'h5555, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF};
   localparam logic [9:0]   DIR_LABS = 10'b0101101011;

   typedef enum logic [1:0] {MIX_TEACHER, MIX_EXTREME, MIX_RAW, MIX_SMALL} mix_type;

   typedef struct packed {
      logic [NFEAT*FEAT_W-1:0] feats;
      logic                    label;
   } sample_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [NFEAT*FEAT_W-1:0]    req_tdata;  // feat_0 .. feat_7
   logic                       req_tuser;  // label_positive
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [MARGIN_W-1:0]        rsp_tdata;  // margin
   logic                       rsp_tuser;  // hinge_active
   logic                       csr_wen;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_W-1:0]           csr_wdata;

   int                         mismatch_count;
   int                         margins_due;
   int                         tx_idle_pct = 24;
   int                         rx_idle_pct = 73;
   bit                         hold_off_req = 1'b0;
   logic signed [FEAT_W-1:0]   teacher [NFEAT];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   linear_svm_sgd_update_core #(.FEATURES(NFEAT)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   svm_sgd_checker #(.FEATURES(NFEAT)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .margins_due    (margins_due)
   );

   // response side: random back-pressure, with one long hold-off on demand
   initial begin
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   function automatic sample_type draw_sample();
      sample_type               s;
      mix_type                  mix;
      int                       r;
      int                       shift;
      longint                   score;
      logic signed [FEAT_W-1:0] v;
      r = $urandom_range(0, 9);
      mix = (r < 5) ? MIX_TEACHER : (r == 5) ? MIX_EXTREME : (r < 8) ? MIX_RAW : MIX_SMALL;
      shift = $urandom_range(0, 10);
      score = 0;
      for (int i = 0; i < NFEAT; i++) begin
         case (mix)
            MIX_TEACHER: begin
               v = $signed(16'($urandom)) >>> shift;
               score += longint'(v) * longint'(teacher[i]);
            end
            MIX_EXTREME: begin
               case ($urandom_range(0, 4))
                  0:       v = 16'h8000;
                  1:       v = 16'h7FFF;
                  2:       v = 16'h0000;
                  3:       v = 16'h0001;
                  default: v = 16'hFFFF;
               endcase
            end
            MIX_RAW:     v = 16'($urandom);
            default:     v = 16'($urandom_range(0, 511)) - 16'd256;
         endcase
         s.feats[i*FEAT_W +: FEAT_W] = v;
      end
      // mostly separable labels so the hinge turns off, with some label noise
      if (mix == MIX_TEACHER)
         s.label = (score >= 0) ^ ($urandom_range(0, 9) == 0);
      else
         s.label = 1'($urandom_range(0, 1));
      return s;
   endfunction

   // offer one request, with a random gap before it; returns at a falling edge
   task automatic offer(input sample_type s);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s.feats;
      req_tuser  <= s.label;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // wait for every outstanding response
   task automatic drain();
      do @(negedge clock); while (margins_due != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      sample_type s;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      foreach (teacher[i]) teacher[i] = 16'($urandom);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests at the reset settings; feature 0 stays zero so w0 stays zero
      for (int k = 0; k < 10; k++) begin
         s.feats = '0;
         for (int i = 1; i < NFEAT; i++) s.feats[i*FEAT_W +: FEAT_W] = DIR_VALS[k*16 +: 16];
         s.label = DIR_LABS[k];
         offer(s);
      end
      for (int i = 1; i < NFEAT; i++) begin
         s.feats = '0;
         s.feats[i*FEAT_W +: FEAT_W] = 16'h8000;
         s.label = i[0];
         offer(s);
      end
      req_tvalid <= 1'b0;
      drain();

      // step 0.5, no decay: w0 climbs by 0.5 so the third request lands on margin 1.0
      write_csr(CSR_STEP_SIZE, 32'h0000_8000);
      write_csr(CSR_REG_LAMBDA, 32'd0);
      repeat (4) begin
         s.feats = '0;
         s.feats[FEAT_W-1:0] = 16'h4000;
         s.label = 1'b1;
         offer(s);
      end
      req_tvalid <= 1'b0;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         tx_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 73 : 0;
         rx_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 24 : 0;
         case (ph)
            0: begin
               // upper bits of the step write must be dropped
               write_csr(CSR_STEP_SIZE, 32'hA5C3_FFFF);
               write_csr(CSR_REG_LAMBDA, 32'd0);
            end
            1: begin
               write_csr(CSR_STEP_SIZE, 32'd0);
               write_csr(CSR_REG_LAMBDA, 32'hFFFF_FFFF);
            end
            2: begin
               write_csr(CSR_STEP_SIZE, 32'h0000_FFFF);
               write_csr(CSR_REG_LAMBDA, 32'hFFFF_FFFF);
            end
            3: begin
               write_csr(CSR_STEP_SIZE, $urandom);
               write_csr(CSR_REG_LAMBDA, $urandom);
            end
            4: begin
               write_csr(CSR_STEP_SIZE, 32'd1);
               write_csr(CSR_REG_LAMBDA, 32'd1);
               hold_off_req = 1'b1;
            end
            default: begin
               write_csr(CSR_STEP_SIZE, CSR_W'(STEP_RESET));
               write_csr(CSR_REG_LAMBDA, 32'($urandom_range(0, 1 << 20)));
            end
         endcase
         repeat (PHASE_ITEMS) offer(draw_sample());
         req_tvalid <= 1'b0;
         drain();
      end

      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
